FILE: design/ssac_pkg.sv
package ssac_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_READY   = 3'd0,
    REG_RECT_X  = 3'd1,
    REG_RECT_Y  = 3'd2,
    REG_RECT_W  = 3'd3,
    REG_RECT_H  = 3'd4,
    REG_VARIANT = 3'd5,
    REG_PRESSED = 3'd6
  } cfg_reg_e;

  localparam logic ActWrite   = 1'b0;
  localparam logic ActCompose = 1'b1;

  // s_axis tdata fields, highest bit first
  typedef struct packed {
    logic [23:0] below_color;
    logic [11:0] pixel_y;
    logic [11:0] pixel_x;
    logic [7:0]  sheet_alpha;
    logic [23:0] sheet_color;
    logic [14:0] sheet_address;
    logic        action;
  } in_item_t;

  typedef struct packed {
    logic        ready_cfg;
    logic [12:0] rect_x;
    logic [12:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [3:0]  variant;
    logic        pressed;
  } cfg_t;

  // queue entry from front to back
  typedef struct packed {
    logic        is_write;
    logic [14:0] address;
    logic [31:0] wdata;
    logic        in_rect;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [23:0] below_color;
  } front_item_t;

  // divide by 255, rounded down, of a value below 255*255+128
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [17:0] t;
    begin
      t = {1'b0, v} + 18'd1 + {10'd0, v[15:8]};
      div255 = t[15:8];
    end
  endfunction

  function automatic logic [7:0] shade(input logic [7:0] c);
    logic [9:0] t;
    begin
      t = {2'b0, c} + {1'b0, c, 1'b0};
      shade = t[9:2];
    end
  endfunction

endpackage

FILE: design/ssac_front.sv
module ssac_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ssac_pkg::in_item_t    item_i,
  input  ssac_pkg::cfg_t        cfg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ssac_pkg::front_item_t item_o
);
  import ssac_pkg::*;

  localparam int unsigned Depth = 2;

  front_item_t fifo_q [Depth];
  logic [1:0] cnt_q;
  logic       wptr_q, rptr_q;
  front_item_t cls;
  logic signed [13:0] ddx, ddy;
  logic push, pop;

  always_comb begin
    ddx = $signed({2'b0, item_i.pixel_x}) - $signed({cfg_i.rect_x[12], cfg_i.rect_x});
    ddy = $signed({2'b0, item_i.pixel_y}) - $signed({cfg_i.rect_y[12], cfg_i.rect_y});
    cls.is_write    = (item_i.action == ActWrite);
    cls.address     = item_i.sheet_address;
    cls.wdata       = {item_i.sheet_alpha, item_i.sheet_color};
    cls.in_rect     = cfg_i.ready_cfg && (cfg_i.variant < 4'd9) &&
                      !ddx[13] && !ddy[13] &&
                      (ddx[12:0] < {1'b0, cfg_i.rect_w}) &&
                      (ddy[12:0] < {1'b0, cfg_i.rect_h});
    cls.dx          = ddx[12:0];
    cls.dy          = ddy[12:0];
    cls.below_color = item_i.below_color;
  end

  assign ready_o = (cnt_q != 2'd2);
  assign push    = valid_i && ready_o;
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && ready_i;
  assign item_o  = fifo_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

FILE: design/ssac_back.sv
module ssac_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  ssac_pkg::front_item_t item_i,
  input  ssac_pkg::cfg_t        cfg_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [25:0]           data_o
);
  import ssac_pkg::*;

  localparam int unsigned DepthMem = 24192;
  localparam int unsigned Stages = 13;
  localparam int unsigned WrStages = 12;

  // per-stage payload through the divider pipeline
  typedef struct packed {
    logic        in_rect;
    logic [11:0] rem_x;
    logic [11:0] rem_y;
    logic [7:0]  qx;
    logic [7:0]  qy;
    logic [23:0] below;
  } dv_t;

  // sheet write carried down to the read stage to keep order with reads
  typedef struct packed {
    logic [14:0] addr;
    logic [31:0] data;
  } wr_t;

  logic [31:0] mem [DepthMem];
  logic        adv;
  logic [Stages-1:0] v_q;
  logic [WrStages-1:0] wr_v_q;
  wr_t         wr_q [WrStages];
  logic [20:0] nx_q, ny_q;
  dv_t         dv_q [9];
  logic        in_q;
  logic [23:0] bel_q, bel2_q;
  logic [7:0]  sx_q, sy_q;
  logic [14:0] idx_q;
  logic [31:0] rd_q;
  logic        in2_q, in3_q;
  logic [23:0] bel3_q;
  logic [7:0]  base_x, base_y;
  logic [25:0] out_q;
  logic        out_v_q;
  logic [25:0] res;
  logic        res_v;

  // stage occupancy: 0 multiply, 1 load, 2..9 division bits, 10 offset, 11 index,
  // 12 read and write, then blend into the output register
  assign adv     = !out_v_q || ready_i;
  assign ready_o = adv;

  always_comb begin
    case (cfg_i.variant)
      4'd0: begin base_x = 8'd0;  base_y = 8'd0;   end
      4'd1: begin base_x = 8'd48; base_y = 8'd0;   end
      4'd2: begin base_x = 8'd96; base_y = 8'd0;   end
      4'd3: begin base_x = 8'd0;  base_y = 8'd56;  end
      4'd4: begin base_x = 8'd48; base_y = 8'd56;  end
      4'd5: begin base_x = 8'd96; base_y = 8'd56;  end
      4'd6: begin base_x = 8'd0;  base_y = 8'd112; end
      4'd7: begin base_x = 8'd48; base_y = 8'd112; end
      4'd8: begin base_x = 8'd96; base_y = 8'd112; end
      default: begin base_x = 8'd0; base_y = 8'd0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_q[0] <= '{addr: item_i.address, data: item_i.wdata};
      for (int k = 1; k < WrStages; k++) begin
        wr_q[k] <= wr_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && wr_v_q[WrStages-1]) begin
      mem[wr_q[WrStages-1].addr] <= wr_q[WrStages-1].data;
    end
  end

  // stage 0: scale numerators
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nx_q  <= {9'd0, item_i.dx[11:0]} * 21'd48;
      ny_q  <= {9'd0, item_i.dy[11:0]} * 21'd56;
      in_q  <= item_i.in_rect;
      bel_q <= item_i.below_color;
    end
  end

  // restoring division, quotient below 256
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= '{in_rect: in_q, rem_x: 12'(nx_q >> 8), rem_y: 12'(ny_q >> 8),
                   qx: nx_q[7:0], qy: ny_q[7:0], below: bel_q};
      for (int k = 1; k < 9; k++) begin
        logic [12:0] tx, ty;
        tx = {dv_q[k-1].rem_x, dv_q[k-1].qx[7]};
        ty = {dv_q[k-1].rem_y, dv_q[k-1].qy[7]};
        dv_q[k].in_rect <= dv_q[k-1].in_rect;
        dv_q[k].below   <= dv_q[k-1].below;
        if (tx >= {1'b0, cfg_i.rect_w}) begin
          dv_q[k].rem_x <= 12'(tx - {1'b0, cfg_i.rect_w});
          dv_q[k].qx    <= {dv_q[k-1].qx[6:0], 1'b1};
        end else begin
          dv_q[k].rem_x <= tx[11:0];
          dv_q[k].qx    <= {dv_q[k-1].qx[6:0], 1'b0};
        end
        if (ty >= {1'b0, cfg_i.rect_h}) begin
          dv_q[k].rem_y <= 12'(ty - {1'b0, cfg_i.rect_h});
          dv_q[k].qy    <= {dv_q[k-1].qy[6:0], 1'b1};
        end else begin
          dv_q[k].rem_y <= ty[11:0];
          dv_q[k].qy    <= {dv_q[k-1].qy[6:0], 1'b0};
        end
      end
      sx_q   <= base_x + dv_q[8].qx;
      sy_q   <= base_y + dv_q[8].qy;
      in2_q  <= dv_q[8].in_rect;
      bel2_q <= dv_q[8].below;
      idx_q  <= {7'd0, sy_q} * 15'd144 + {7'd0, sx_q};
      in3_q  <= in2_q;
      bel3_q <= bel2_q;
      rd_q   <= mem[idx_q];
    end
  end

  // pipeline control: one slot per register stage
  logic        in4_q;
  logic [23:0] bel4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in4_q  <= in3_q;
      bel4_q <= bel3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      wr_v_q <= '0;
    end else if (adv) begin
      v_q    <= {v_q[Stages-2:0], valid_i && !item_i.is_write};
      wr_v_q <= {wr_v_q[WrStages-2:0],
                 valid_i && item_i.is_write && (item_i.address < 15'(DepthMem))};
    end
  end

  always_comb begin
    logic [7:0]  a, na, c;
    logic [23:0] above;
    logic [23:0] col;
    a = rd_q[31:24];
    na = 8'd255 - a;
    above = rd_q[23:0];
    if (cfg_i.pressed) begin
      above = {shade(above[23:16]), shade(above[15:8]), shade(above[7:0])};
    end
    for (int ch = 0; ch < 3; ch++) begin
      c = div255({1'b0, {8'd0, above[ch*8 +: 8]} * {8'd0, a}} +
                 {1'b0, {8'd0, bel4_q[ch*8 +: 8]} * {8'd0, na}} + 17'd127);
      col[ch*8 +: 8] = c;
    end
    if (in4_q && a != 8'd0) begin
      res = {a[7], 1'b1, col};
    end else begin
      res = {2'b00, bel4_q};
    end
    res_v = v_q[Stages-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_v) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= res_v;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q)) else $error("pipeline moved while stalled");
  a_hit_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q[25] |-> out_q[24]) else $error("hit without cover");
  a_wr_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && valid_i && item_i.is_write |=> !v_q[0]) else $error("write made a result");

endmodule

FILE: design/scaled_sprite_alpha_compositor_core.sv
// path: the front queue, then the back pipeline including the output register
// throughput: one item per cycle; the back pipeline holds whole while the output stalls
// division by rect_w and rect_h is an 8-stage restoring pipeline, one quotient bit a stage
// sheet memory is one write port and one registered read port, contents undefined until written
// reset (rst_ni low, asynchronous) clears handshakes and valid bits and loads config defaults (rect_w 48, rect_h 56)
module scaled_sprite_alpha_compositor_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, sheet_address, sheet_color, sheet_alpha, pixel_x, pixel_y, below_color
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_color, covered, hit
  output logic [31:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i
);
  import ssac_pkg::*;

  cfg_t        cfg_q;
  front_item_t q_item;
  logic        q_valid, q_ready;
  logic [25:0] res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{ready_cfg: 1'b0, rect_x: '0, rect_y: '0, rect_w: 12'd48,
                 rect_h: 12'd56, variant: '0, pressed: 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_READY:   cfg_q.ready_cfg <= cfg_data_i[0];
        REG_RECT_X:  cfg_q.rect_x    <= cfg_data_i;
        REG_RECT_Y:  cfg_q.rect_y    <= cfg_data_i;
        REG_RECT_W:  cfg_q.rect_w    <= cfg_data_i[11:0];
        REG_RECT_H:  cfg_q.rect_h    <= cfg_data_i[11:0];
        REG_VARIANT: cfg_q.variant   <= cfg_data_i[3:0];
        REG_PRESSED: cfg_q.pressed   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ssac_front u_front (
    .clk_i, .rst_ni,
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item_t'(s_axis_tdata)),
    .cfg_i   (cfg_q),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  ssac_back u_back (
    .clk_i, .rst_ni,
    .valid_i (q_valid),
    .ready_o (q_ready),
    .item_i  (q_item),
    .cfg_i   (cfg_q),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {6'd0, res[25], res[24], res[23:0]};

endmodule

FILE: dv/scaled_sprite_alpha_compositor_check.sv
`timescale 1ns / 100ps

module scaled_sprite_alpha_compositor_check
  import ssac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [95:0]  s_tdata_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [31:0]  m_tdata_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [12:0]  cfg_data_i,
  output int           pending_o,
  output int           fails_o
);

  typedef struct packed {
    logic [23:0] color;
    logic        covered;
    logic        hit;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];
  logic [31:0]   sheet_mem [0:24191];

  logic sheet_ready;
  int   rect_left, rect_top, rect_wd, rect_ht, cell_sel;
  logic shade_on;

  function automatic pixel_result_t composite_pixel(in_item_t it);
    int            px, py, sx, sy, idx, a;
    logic [31:0]   entry;
    logic [23:0]   above;
    pixel_result_t r;
    px = int'(it.pixel_x);
    py = int'(it.pixel_y);
    r.color   = it.below_color;
    r.covered = 1'b0;
    r.hit     = 1'b0;
    if (sheet_ready && cell_sel < 9 && rect_wd != 0 && rect_ht != 0 &&
        px >= rect_left && py >= rect_top &&
        px < rect_left + rect_wd && py < rect_top + rect_ht) begin
      sx = (cell_sel % 3) * 48 + (px - rect_left) * 48 / rect_wd;
      sy = (cell_sel / 3) * 56 + (py - rect_top) * 56 / rect_ht;
      idx = sy * 144 + sx;
      entry = (idx < 24192) ? sheet_mem[idx] : 32'd0;
      a = int'(entry[31:24]);
      if (a != 0) begin
        above = entry[23:0];
        for (int k = 0; k < 3; k++) begin
          if (shade_on) above[8*k +: 8] = 8'(int'(above[8*k +: 8]) * 3 / 4);
          r.color[8*k +: 8] = 8'((int'(above[8*k +: 8]) * a +
                                  int'(it.below_color[8*k +: 8]) * (255 - a) + 127) / 255);
        end
        r.covered = 1'b1;
        r.hit     = (a >= 128);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t      it;
    pixel_result_t want;
    if (!rst_ni) begin
      sheet_ready = 1'b0;
      rect_left   = 0;
      rect_top    = 0;
      rect_wd     = 48;
      rect_ht     = 56;
      cell_sel    = 0;
      shade_on    = 1'b0;
      expected_pixels.delete();
      fails_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_READY:   sheet_ready = cfg_data_i[0];
          REG_RECT_X:  rect_left   = int'($signed(cfg_data_i));
          REG_RECT_Y:  rect_top    = int'($signed(cfg_data_i));
          REG_RECT_W:  rect_wd     = int'(cfg_data_i[11:0]);
          REG_RECT_H:  rect_ht     = int'(cfg_data_i[11:0]);
          REG_VARIANT: cell_sel    = int'(cfg_data_i[3:0]);
          REG_PRESSED: shade_on    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        it = in_item_t'(s_tdata_i);
        if (it.action == ActWrite) begin
          if (it.sheet_address < 24192)
            sheet_mem[it.sheet_address] = {it.sheet_alpha, it.sheet_color};
        end else begin
          expected_pixels.push_back(composite_pixel(it));
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transfer %h", m_tdata_i);
          fails_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata_i[23:0] !== want.color) begin
            $error("out_color expected %h actual %h", want.color, m_tdata_i[23:0]);
            fails_o++;
          end
          if (m_tdata_i[24] !== want.covered) begin
            $error("covered expected %b actual %b", want.covered, m_tdata_i[24]);
            fails_o++;
          end
          if (m_tdata_i[25] !== want.hit) begin
            $error("hit expected %b actual %b", want.hit, m_tdata_i[25]);
            fails_o++;
          end
        end
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

FILE: dv/scaled_sprite_alpha_compositor_core_test.sv
`timescale 1ns / 100ps

module scaled_sprite_alpha_compositor_core_test;
  import ssac_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [31:0]  m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [12:0]  cfg_data_i;
  int           pending, fails;

  logic calm, squeeze;
  bit   written [0:24191];
  logic cur_ready;
  int   cur_x, cur_y, cur_w, cur_h, cur_cell;

  scaled_sprite_alpha_compositor_core DUT (.*);

  scaled_sprite_alpha_compositor_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .fails_o     (fails)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sink side: random stalls plus one long hold-off
  int stall_left, hold_left;
  logic squeezed;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      squeezed   = 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (squeeze && !squeezed) begin
      squeezed = 1'b1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int sheet_index(int px, int py);
    if (!cur_ready || cur_cell >= 9 || cur_w == 0 || cur_h == 0) return -1;
    if (px < cur_x || py < cur_y || px >= cur_x + cur_w || py >= cur_y + cur_h) return -1;
    return ((cur_cell / 3) * 56 + (py - cur_y) * 56 / cur_h) * 144 +
           (cur_cell % 3) * 48 + (px - cur_x) * 48 / cur_w;
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd128;
      3: return 8'd127;
      4: return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic send(in_item_t it);
    int  g;
    bit  ok;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    if (it.action == ActWrite && it.sheet_address < 24192) written[it.sheet_address] = 1'b1;
  endtask

  task automatic write_px(int addr, logic [23:0] color, logic [7:0] alpha);
    in_item_t it;
    it = '0;
    it.action        = ActWrite;
    it.sheet_address = 15'(addr);
    it.sheet_color   = color;
    it.sheet_alpha   = alpha;
    it.pixel_x       = 12'($urandom);
    it.pixel_y       = 12'($urandom);
    it.below_color   = 24'($urandom);
    send(it);
  endtask

  task automatic compose(int px, int py, logic [23:0] below);
    in_item_t it;
    int       idx;
    idx = sheet_index(px, py);
    if (idx >= 0 && idx < 24192 && !written[idx])
      write_px(idx, 24'($urandom), pick_alpha());
    it = '0;
    it.action        = ActCompose;
    it.sheet_address = 15'($urandom);
    it.sheet_color   = 24'($urandom);
    it.sheet_alpha   = 8'($urandom);
    it.pixel_x       = 12'(px);
    it.pixel_y       = 12'(py);
    it.below_color   = below;
    send(it);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e r, logic [12:0] v);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (r)
      REG_READY:   cur_ready = v[0];
      REG_RECT_X:  cur_x     = int'($signed(v));
      REG_RECT_Y:  cur_y     = int'($signed(v));
      REG_RECT_W:  cur_w     = int'(v[11:0]);
      REG_RECT_H:  cur_h     = int'(v[11:0]);
      REG_VARIANT: cur_cell  = int'(v[3:0]);
      default: ;
    endcase
  endtask

  task automatic run_random(int n);
    int addr, px, py;
    repeat (n) begin
      if ($urandom_range(0, 99) < 35) begin
        if (cur_cell < 9 && $urandom_range(0, 1) == 1)
          addr = ((cur_cell / 3) * 56 + $urandom_range(0, 55)) * 144 +
                 (cur_cell % 3) * 48 + $urandom_range(0, 47);
        else
          addr = $urandom_range(0, 32767);
        write_px(addr, 24'($urandom), pick_alpha());
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          px = clamp12(cur_x + $urandom_range(0, cur_w + 3) - 2);
          py = clamp12(cur_y + $urandom_range(0, cur_h + 3) - 2);
        end else begin
          px = $urandom_range(0, 4095);
          py = $urandom_range(0, 4095);
        end
        compose(px, py, 24'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    calm          = 1'b0;
    squeeze       = 1'b0;
    cur_ready     = 1'b0;
    cur_x = 0; cur_y = 0; cur_w = 48; cur_h = 56; cur_cell = 0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sheet not ready yet
    run_random(80);

    set_reg(REG_READY, 13'd1);
    write_px(0, 24'hffffff, 8'd255);
    compose(0, 0, 24'h000000);
    write_px(1, 24'h000000, 8'd0);
    compose(1, 0, 24'hffffff);
    write_px(2, 24'h123456, 8'd128);
    compose(2, 0, 24'hfedcba);
    write_px(3, 24'hff00ff, 8'd127);
    compose(3, 0, 24'h00ff00);
    write_px(55 * 144 + 47, 24'h00ff00, 8'd1);
    compose(47, 55, 24'hff00ff);
    compose(48, 0, 24'habcdef);
    compose(0, 56, 24'h654321);
    compose(4095, 4095, 24'hffffff);
    write_px(24191, 24'hffffff, 8'd255);
    write_px(24192, 24'h0f0f0f, 8'd255);
    write_px(32767, 24'hf0f0f0, 8'd255);
    run_random(150);

    set_reg(REG_VARIANT, 13'd8);
    set_reg(REG_PRESSED, 13'd1);
    set_reg(REG_RECT_X, 13'h1000);
    set_reg(REG_RECT_Y, 13'h1000);
    set_reg(REG_RECT_W, 13'd4095);
    set_reg(REG_RECT_H, 13'd4095);
    run_random(150);

    set_reg(REG_RECT_X, 13'd4095);
    set_reg(REG_RECT_Y, 13'd4095);
    set_reg(REG_RECT_W, 13'd1);
    set_reg(REG_RECT_H, 13'd1);
    set_reg(REG_VARIANT, 13'd4);
    set_reg(REG_PRESSED, 13'd0);
    compose(4095, 4095, 24'h808080);
    run_random(100);

    set_reg(REG_RECT_X, 13'd0);
    set_reg(REG_RECT_Y, 13'd0);
    set_reg(REG_RECT_W, 13'd48);
    set_reg(REG_RECT_H, 13'd56);
    set_reg(REG_VARIANT, 13'd15);
    run_random(80);

    set_reg(REG_RECT_W, 13'd0);
    set_reg(REG_RECT_H, 13'd0);
    set_reg(REG_VARIANT, 13'd2);
    run_random(80);

    for (int i = 0; i < 6; i++) begin
      set_reg(REG_RECT_X, 13'($urandom_range(0, 4200) - 100));
      set_reg(REG_RECT_Y, 13'($urandom_range(0, 4200) - 100));
      set_reg(REG_RECT_W, 13'($urandom_range(1, 160)));
      set_reg(REG_RECT_H, 13'($urandom_range(1, 160)));
      set_reg(REG_VARIANT, 13'($urandom_range(0, 8)));
      set_reg(REG_PRESSED, 13'($urandom_range(0, 1)));
      calm = (i == 1);
      if (i == 3) squeeze <= 1'b1;
      run_random(100);
    end
    calm = 1'b0;

    set_reg(REG_READY, 13'd0);
    run_random(60);

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
